// File: hdl/iafc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iafc_pkg
// Shared types and constants for the in-application flash controller:
// register map, trigger codes, command codes and controller/datapath links.
// ----------------------------------------------------------------------------
package iafc_pkg;

  // Bus access kind
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Register map
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_ADDR_HI = 3'd1;
  localparam logic [2:0] REG_ADDR_LO = 3'd2;
  localparam logic [2:0] REG_CMD     = 3'd3;
  localparam logic [2:0] REG_TRIG    = 3'd4;
  localparam logic [2:0] REG_CTRL    = 3'd5;

  // Trigger sequence
  localparam logic [7:0] TRIG_FIRST  = 8'h46;
  localparam logic [7:0] TRIG_SECOND = 8'hB9;

  // Control register enable bit
  localparam int unsigned CTRL_ENABLE_BIT = 7;

  // Flash command codes (low three bits of the command register)
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_PROGRAM = 3'd2;
  localparam logic [2:0] CMD_ERASE   = 3'd3;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Decoded meaning of the word at the input
  typedef enum logic [2:0] {
    OP_PLAIN  = 3'd0,
    OP_ARM    = 3'd1,
    OP_DISARM = 3'd2,
    OP_FAIL   = 3'd3,
    OP_READ   = 3'd4,
    OP_PROG   = 3'd5,
    OP_ERASE  = 3'd6
  } iafc_op_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic mem_rd;     // read flash at the current address
    logic load_data;  // data register takes the flash read data
    logic prog_wr;    // write back old AND data
    logic sweep_clr;  // restart the sector sweep counter
    logic erase_wr;   // write erased byte at the sweep address
    logic clear_wr;   // write erased byte at the clearing address
    logic out_load;   // load the output register
    logic out_bus;    // output rdata comes from the register read mux
    logic out_done;
    logic out_fail;
  } iafc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    iafc_op_t op;
    logic     sweep_last;
    logic     clear_last;
  } iafc_stat_t;

endpackage

// File: hdl/iafc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iafc_datapath
// Register file, trigger arming, flash array with its single port, sweep
// counters for sector erase and power-up clearing, and the output register.
// ----------------------------------------------------------------------------
module iafc_datapath import iafc_pkg::*; #(
  parameter int ADDR_BITS    = 14,
  parameter int SECTOR_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       action,
  input  logic [2:0] reg_select,
  input  logic [7:0] wdata,
  input  iafc_cmd_t  cmd,
  output iafc_stat_t stat,
  output logic [7:0] rdata,
  output logic       done_res,
  output logic       fail
);

  localparam int DEPTH    = 1 << ADDR_BITS;
  localparam int SEC_BITS = $clog2(SECTOR_BYTES);
  localparam int SUM_W    = (ADDR_BITS > SEC_BITS) ? ADDR_BITS : SEC_BITS;
  localparam logic [ADDR_BITS-1:0] SEC_MASK = ADDR_BITS'(SECTOR_BYTES - 1);
  localparam logic [SEC_BITS-1:0]  SEC_LAST = SEC_BITS'(SECTOR_BYTES - 1);

  logic [7:0] data_register;
  logic [7:0] address_high;
  logic [7:0] address_low;
  logic [7:0] command_register;
  logic [7:0] control_register;
  logic       trigger_armed;

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;

  logic [ADDR_BITS-1:0] clr_cnt;
  logic [SEC_BITS-1:0]  sweep_cnt;

  logic [15:0]          addr_full;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] sec_base;
  logic [SUM_W-1:0]     sweep_sum;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [7:0]           wr_byte;
  logic                 wr_en;
  logic [7:0]           rd_value;
  logic                 is_write;
  logic                 enabled;

  // Flash address and sector sweep address
  always_comb begin
    addr_full = {address_high, address_low};
    addr      = addr_full[ADDR_BITS-1:0];
    sec_base  = addr & ~SEC_MASK;
    sweep_sum = SUM_W'(sec_base) + SUM_W'(sweep_cnt);
  end

  // Decode the word at the input
  always_comb begin
    is_write = (action == ACT_WRITE);
    enabled  = control_register[CTRL_ENABLE_BIT];
    stat.op  = OP_PLAIN;
    if (is_write && reg_select == REG_TRIG) begin
      if (wdata == TRIG_FIRST) begin
        stat.op = OP_ARM;
      end else if (wdata == TRIG_SECOND) begin
        if (!trigger_armed || !enabled) begin
          stat.op = OP_FAIL;
        end else begin
          case (command_register[2:0])
            CMD_READ:    stat.op = OP_READ;
            CMD_PROGRAM: stat.op = OP_PROG;
            CMD_ERASE:   stat.op = OP_ERASE;
            default:     stat.op = OP_FAIL;
          endcase
        end
      end else begin
        stat.op = OP_DISARM;
      end
    end
    stat.sweep_last = (sweep_cnt == SEC_LAST);
    stat.clear_last = (clr_cnt == '1);
  end

  // Register read mux
  always_comb begin
    rd_value = 8'h00;
    if (action == ACT_READ) begin
      case (reg_select)
        REG_DATA:    rd_value = data_register;
        REG_ADDR_HI: rd_value = address_high;
        REG_ADDR_LO: rd_value = address_low;
        REG_CMD:     rd_value = command_register;
        REG_CTRL:    rd_value = control_register;
        default:     rd_value = 8'h00;
      endcase
    end
  end

  // Update the register file on accepted writes and flash reads
  always_ff @(posedge clk) begin
    if (rst) begin
      data_register    <= 8'h00;
      address_high     <= 8'h00;
      address_low      <= 8'h00;
      command_register <= 8'h00;
      control_register <= 8'h00;
      trigger_armed    <= 1'b0;
    end else begin
      if (cmd.load_data) begin
        data_register <= mem_q;
      end
      if (cmd.accept && is_write) begin
        case (reg_select)
          REG_DATA:    data_register    <= wdata;
          REG_ADDR_HI: address_high     <= wdata;
          REG_ADDR_LO: address_low      <= wdata;
          REG_CMD:     command_register <= wdata;
          REG_TRIG:    trigger_armed    <= (wdata == TRIG_FIRST);
          REG_CTRL:    control_register <= wdata;
          default:     ;
        endcase
      end
    end
  end

  // Advance the clearing and sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      sweep_cnt <= '0;
    end else begin
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.sweep_clr) begin
        sweep_cnt <= '0;
      end else if (cmd.erase_wr) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
    end
  end

  // Select the write port
  always_comb begin
    wr_en   = cmd.prog_wr | cmd.erase_wr | cmd.clear_wr;
    wr_addr = addr;
    wr_byte = ERASED_BYTE;
    if (cmd.prog_wr) begin
      wr_byte = mem_q & data_register;
    end else if (cmd.erase_wr) begin
      wr_addr = sweep_sum[ADDR_BITS-1:0];
    end else if (cmd.clear_wr) begin
      wr_addr = clr_cnt;
    end
  end

  // Flash array, one access per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_byte;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[addr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rdata    <= cmd.out_bus ? rd_value : 8'h00;
      done_res <= cmd.out_done;
      fail     <= cmd.out_fail;
    end
  end

endmodule

// File: hdl/iafc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iafc_ctrl
// Controller state machine: clearing pass, input handshake, command
// sequencing for flash read, program and sector erase, output valid.
// ----------------------------------------------------------------------------
module iafc_ctrl import iafc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  iafc_stat_t stat,
  output iafc_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_PROG  = 5'b01000,
    S_ERASE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // Sequence the commands
  always_comb begin
    out_free   = !out_valid || !out_stall;
    in_stall   = !((state == S_IDLE) && out_free);
    cmd        = '0;
    state_next = state;
    cmd.accept = in_valid && !in_stall;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.accept) begin
          case (stat.op)
            OP_READ: begin
              cmd.mem_rd = 1'b1;
              state_next = S_READ;
            end
            OP_PROG: begin
              cmd.mem_rd = 1'b1;
              state_next = S_PROG;
            end
            OP_ERASE: begin
              cmd.sweep_clr = 1'b1;
              state_next    = S_ERASE;
            end
            default: begin
              cmd.out_load = 1'b1;
              cmd.out_bus  = 1'b1;
              cmd.out_fail = (stat.op == OP_FAIL);
            end
          endcase
        end
      end
      S_READ: begin
        cmd.load_data = 1'b1;
        cmd.out_load  = 1'b1;
        cmd.out_done  = 1'b1;
        state_next    = S_IDLE;
      end
      S_PROG: begin
        cmd.prog_wr  = 1'b1;
        cmd.out_load = 1'b1;
        cmd.out_done = 1'b1;
        state_next   = S_IDLE;
      end
      S_ERASE: begin
        cmd.erase_wr = 1'b1;
        if (stat.sweep_last) begin
          cmd.out_load = 1'b1;
          cmd.out_done = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output word overwritten while stalled");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |-> !(cmd.prog_wr || cmd.erase_wr || cmd.clear_wr))
    else $error("flash read and write in the same cycle");

  a_prog_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROG || state == S_READ) |=> (out_valid && state == S_IDLE))
    else $error("flash command finished without a result");

  a_erase_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERASE && !stat.sweep_last) |=> (state == S_ERASE && in_stall))
    else $error("sector erase left early");
`endif

endmodule

// File: hdl/iap_flash_controller.sv
// Register access: result in the next cycle; one word per cycle unless the output stalls.
// Flash read and program: registered array read, then load or write back.
// Sector erase: one byte per cycle through the single array port.
// Reset: registers clear at once; the array is then filled with 0xFF, all
// 2^ADDR_BITS bytes (16384 by default), while the input stays stalled.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iap_flash_controller
// In-application flash controller behind six byte registers with a two-word
// trigger sequence for flash read, byte program and sector erase.
// ----------------------------------------------------------------------------
module iap_flash_controller import iafc_pkg::*; #(
  parameter int ADDR_BITS    = 14,
  parameter int SECTOR_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [2:0] reg_select,
  input  logic [7:0] wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] rdata,
  output logic       done_res,
  output logic       fail
);

  iafc_cmd_t  cmd;
  iafc_stat_t stat;

  iafc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  iafc_datapath #(
    .ADDR_BITS    (ADDR_BITS),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .action     (action),
    .reg_select (reg_select),
    .wdata      (wdata),
    .cmd        (cmd),
    .stat       (stat),
    .rdata      (rdata),
    .done_res   (done_res),
    .fail       (fail)
  );

endmodule
